@@ src/tfsd_pkg.sv @@
// Shared types and codes for the tagged field stream decoder.
package tfsd_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TAG,
        PH_VARINT,
        PH_FIXED,
        PH_LEN,
        PH_PAYLOAD
    } t_phase;

    // Input beat kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // Result event codes
    localparam logic [1:0] EV_SCALAR  = 2'd0;
    localparam logic [1:0] EV_HEADER  = 2'd1;
    localparam logic [1:0] EV_PAYLOAD = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNC     = 2'd1;
    localparam logic [1:0] ERR_OVERLONG  = 2'd2;
    localparam logic [1:0] ERR_BAD_TYPE  = 2'd3;

    // Wire types
    localparam logic [1:0] WT_VARINT  = 2'd0;
    localparam logic [1:0] WT_FIXED64 = 2'd1;
    localparam logic [1:0] WT_LEN     = 2'd2;
    localparam logic [1:0] WT_FIXED32 = 2'd3;

    // Varint and fixed-width bookkeeping
    localparam logic [6:0] VARINT_STEP  = 7'd7;
    localparam logic [6:0] FIXED_STEP   = 7'd8;
    localparam logic [6:0] SHIFT_LIMIT  = 7'd63;
    localparam logic [63:0] FIXED64_LEN = 64'd8;
    localparam logic [63:0] FIXED32_LEN = 64'd4;

    // One decoded result, with a flag that says whether the beat makes one
    typedef struct packed {
        logic        has_res;
        logic [1:0]  event_res;
        logic [31:0] field_number;
        logic [1:0]  wire_type;
        logic [63:0] field_value;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [1:0]  error_code;
    } t_result;

endpackage

@@ src/tagged_field_stream_decoder_top.sv @@
// Top level of the tagged field stream decoder: input register, parser, result register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_kind, i_data_byte
//  out     | from block| o_out_valid / i_out_stall| o_event_res .. o_error_code
//
// One byte is taken per cycle while o_in_stall is low; its result passes through the
// input register and then the result register.
// The parse state updates between the input register and the result register.
// Reset is synchronous, active low, and empties both registers and restarts the parser.
// A stalled result holds; the input side stalls only when a held byte would make a
// result and the result register cannot take it.
module tagged_field_stream_decoder_top
    import tfsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [31:0] o_field_number,
    output logic [1:0]  o_wire_type,
    output logic [63:0] o_field_value,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_payload,
    output logic [1:0]  o_error_code
);

    logic       r_in_vld;
    logic       r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    t_result    step_res;
    logic       out_free;
    logic       adv;

    tfsd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    // Consume the held beat when it makes no result or its result has room
    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && (!step_res.has_res || out_free);
    assign o_in_stall = r_in_vld && !adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_data_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= adv && step_res.has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && adv) begin
            r_out <= step_res;
        end
    end

    // Drive the result ports
    assign o_out_valid    = r_out_vld;
    assign o_event_res    = r_out.event_res;
    assign o_field_number = r_out.field_number;
    assign o_wire_type    = r_out.wire_type;
    assign o_field_value  = r_out.field_value;
    assign o_payload_byte = r_out.payload_byte;
    assign o_last_payload = r_out.last_payload;
    assign o_error_code   = r_out.error_code;

endmodule

@@ src/tfsd_parse.sv @@
// Parse state registers and the per-beat decode logic.
module tfsd_parse
    import tfsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_kind,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase      r_phase,  n_phase;
    logic [63:0] r_acc,    n_acc;
    logic [6:0]  r_shift,  n_shift;
    logic [31:0] r_field,  n_field;
    logic [1:0]  r_type,   n_type;
    logic [63:0] r_left,   n_left;
    logic        r_err,    n_err;

    logic        vi_over;
    logic        vi_done;
    logic [63:0] vi_acc;
    logic [63:0] fx_acc;
    logic [63:0] left_dec;
    logic        left_last;
    logic        mid_field;

    // Shared datapath: varint byte merge, fixed byte merge, countdown
    assign vi_over   = (r_shift > SHIFT_LIMIT);
    assign vi_done   = !i_byte[7];
    assign vi_acc    = r_acc | ({57'd0, i_byte[6:0]} << r_shift[5:0]);
    assign fx_acc    = r_acc | ({56'd0, i_byte} << r_shift[5:0]);
    assign left_dec  = (r_left != 64'd0) ? (r_left - 64'd1) : 64'd0;
    assign left_last = (left_dec == 64'd0);
    assign mid_field = !((r_phase == PH_TAG) && (r_shift == 7'd0));

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_shift = r_shift;
        n_field = r_field;
        n_type  = r_type;
        n_left  = r_left;
        n_err   = r_err;
        if (i_kind == KIND_EOS) begin
            // restart cleanly, drop any error latch
            n_err   = 1'b0;
            n_phase = PH_TAG;
            n_acc   = '0;
            n_shift = '0;
            n_left  = '0;
        end else if (!r_err) begin
            case (r_phase)
                PH_TAG: begin
                    if (vi_over || (vi_done && vi_acc[2])) begin
                        n_err   = 1'b1;
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_shift = '0;
                        n_left  = '0;
                    end else if (vi_done) begin
                        n_type  = vi_acc[1:0];
                        n_field = vi_acc[34:3];
                        n_acc   = '0;
                        n_shift = '0;
                        case (vi_acc[1:0])
                            WT_VARINT:  n_phase = PH_VARINT;
                            WT_LEN:     n_phase = PH_LEN;
                            WT_FIXED64: begin
                                n_phase = PH_FIXED;
                                n_left  = FIXED64_LEN;
                            end
                            default: begin
                                n_phase = PH_FIXED;
                                n_left  = FIXED32_LEN;
                            end
                        endcase
                    end else begin
                        n_acc   = vi_acc;
                        n_shift = r_shift + VARINT_STEP;
                    end
                end
                PH_VARINT: begin
                    if (vi_over || vi_done) begin
                        n_err   = vi_over;
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_shift = '0;
                        n_left  = '0;
                    end else begin
                        n_acc   = vi_acc;
                        n_shift = r_shift + VARINT_STEP;
                    end
                end
                PH_FIXED: begin
                    n_acc   = fx_acc;
                    n_shift = r_shift + FIXED_STEP;
                    n_left  = left_dec;
                    if (left_last) begin
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_shift = '0;
                    end
                end
                PH_LEN: begin
                    if (vi_over) begin
                        n_err   = 1'b1;
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_shift = '0;
                        n_left  = '0;
                    end else if (vi_done) begin
                        n_left  = vi_acc;
                        n_acc   = '0;
                        n_shift = '0;
                        n_phase = (vi_acc == 64'd0) ? PH_TAG : PH_PAYLOAD;
                    end else begin
                        n_acc   = vi_acc;
                        n_shift = r_shift + VARINT_STEP;
                    end
                end
                PH_PAYLOAD: begin
                    n_left = left_dec;
                    if (left_last) begin
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_shift = '0;
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_shift = '0;
                    n_left  = '0;
                end
            endcase
        end
    end

    // Result for the current beat
    always_comb begin
        o_res = '0;
        if (i_kind == KIND_EOS) begin
            if (!r_err && mid_field) begin
                o_res.has_res    = 1'b1;
                o_res.event_res  = EV_ERROR;
                o_res.error_code = ERR_TRUNC;
            end
        end else if (!r_err) begin
            case (r_phase)
                PH_TAG: begin
                    if (vi_over) begin
                        o_res.has_res    = 1'b1;
                        o_res.event_res  = EV_ERROR;
                        o_res.error_code = ERR_OVERLONG;
                    end else if (vi_done && vi_acc[2]) begin
                        o_res.has_res    = 1'b1;
                        o_res.event_res  = EV_ERROR;
                        o_res.error_code = ERR_BAD_TYPE;
                    end
                end
                PH_VARINT, PH_LEN: begin
                    if (vi_over) begin
                        o_res.has_res    = 1'b1;
                        o_res.event_res  = EV_ERROR;
                        o_res.error_code = ERR_OVERLONG;
                    end else if (vi_done) begin
                        o_res.has_res      = 1'b1;
                        o_res.event_res    = (r_phase == PH_LEN) ? EV_HEADER : EV_SCALAR;
                        o_res.field_number = r_field;
                        o_res.wire_type    = r_type;
                        o_res.field_value  = vi_acc;
                    end
                end
                PH_FIXED: begin
                    if (left_last) begin
                        o_res.has_res      = 1'b1;
                        o_res.event_res    = EV_SCALAR;
                        o_res.field_number = r_field;
                        o_res.wire_type    = r_type;
                        o_res.field_value  = fx_acc;
                    end
                end
                PH_PAYLOAD: begin
                    o_res.has_res      = 1'b1;
                    o_res.event_res    = EV_PAYLOAD;
                    o_res.field_number = r_field;
                    o_res.wire_type    = r_type;
                    o_res.payload_byte = i_byte;
                    o_res.last_payload = left_last;
                end
                default: begin
                    o_res = '0;
                end
            endcase
        end
    end

    // Advance parse state on each consumed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_acc   <= '0;
            r_shift <= '0;
            r_field <= '0;
            r_type  <= '0;
            r_left  <= '0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_shift <= n_shift;
            r_field <= n_field;
            r_type  <= n_type;
            r_left  <= n_left;
            r_err   <= n_err;
        end
    end

endmodule
